@@ sv/ssu_pkg.sv @@
package ssu_pkg;

  // Width of one stored element.
  localparam int unsigned DataWidth = 32;

  // Controller states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GAP_INIT,
    ST_POS_RD,
    ST_POS_LATCH,
    ST_CMP,
    ST_PLACE,
    ST_NEXT_GAP,
    ST_OUT_RD,
    ST_OUT_LD
  } ssu_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take one input element
    logic gap_init;   // first gap is half the count
    logic pos_rd;     // read the element at pos
    logic pos_latch;  // hold it and read the element one gap below
    logic shift;      // move the larger element up one gap
    logic place;      // write the held element into the hole
    logic gap_next;   // halve the gap
    logic out_rd;     // read the next sorted element
    logic out_ld;     // load the output register
  } ssu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic half_zero;  // count / 2 is zero
    logic next_zero;  // gap / 2 is zero
    logic greater;    // element below is strictly larger than the held one
    logic hole_more;  // after a shift, another element lies one gap below
    logic pos_end;    // pos is the last index of the set
    logic out_free;   // output register can take a new result
    logic out_last;   // result index is the final one
  } ssu_status_t;

endpackage

@@ sv/ssu_ram.sv @@
module ssu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ssu_ctrl.sv @@
module ssu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_stall_o,
  input  ssu_pkg::ssu_status_t status_i,
  output ssu_pkg::ssu_cmd_t    cmd_o
);

  import ssu_pkg::*;

  ssu_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (last_i) begin
            state_d = ST_GAP_INIT;
          end
        end
      end
      ST_GAP_INIT: begin
        cmd_o.gap_init = 1'b1;
        state_d = status_i.half_zero ? ST_OUT_RD : ST_POS_RD;
      end
      ST_POS_RD: begin
        cmd_o.pos_rd = 1'b1;
        state_d = ST_POS_LATCH;
      end
      ST_POS_LATCH: begin
        cmd_o.pos_latch = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.greater) begin
          cmd_o.shift = 1'b1;
          state_d = status_i.hole_more ? ST_CMP : ST_PLACE;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d = status_i.pos_end ? ST_NEXT_GAP : ST_POS_RD;
      end
      ST_NEXT_GAP: begin
        cmd_o.gap_next = 1'b1;
        state_d = status_i.next_zero ? ST_OUT_RD : ST_POS_RD;
      end
      ST_OUT_RD: begin
        cmd_o.out_rd = 1'b1;
        state_d = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = status_i.out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

@@ sv/ssu_dpath.sv @@
module ssu_dpath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic signed [ssu_pkg::DataWidth-1:0] value_i,
  input  ssu_pkg::ssu_cmd_t              cmd_i,
  output ssu_pkg::ssu_status_t           status_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [ssu_pkg::DataWidth-1:0] sorted_value_o,
  output logic                           last_res_o,
  output logic                           truncated_o
);

  import ssu_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CapCount = CW'(MAX_ITEMS);

  logic [CW-1:0] count_q, gap_q, pos_q, hole_q, idx_q;
  logic          ovf_q;
  logic signed [DataWidth-1:0] held_q;

  logic                 out_valid_q;
  logic signed [DataWidth-1:0] out_value_q;
  logic                 out_last_q, out_trunc_q;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [DataWidth-1:0] wdata, rdata;

  logic [CW-1:0] hole_dn, pos_dn, half_count, half_gap, pos_inc, idx_inc;

  assign hole_dn    = hole_q - gap_q;
  assign pos_dn     = pos_q - gap_q;
  assign half_count = count_q >> 1;
  assign half_gap   = gap_q >> 1;
  assign pos_inc    = pos_q + CW'(1);
  assign idx_inc    = idx_q + CW'(1);

  // Status toward the controller.
  always_comb begin
    status_o.half_zero = (half_count == '0);
    status_o.next_zero = (half_gap == '0);
    status_o.greater   = ($signed(rdata) > held_q);
    status_o.hole_more = (hole_dn >= gap_q);
    status_o.pos_end   = (pos_inc >= count_q);
    status_o.out_free  = !out_valid_q || !out_stall_i;
    status_o.out_last  = (idx_inc == count_q);
  end

  // Memory port selection: one write and one read address per cycle.
  always_comb begin
    we    = 1'b0;
    waddr = count_q[AW-1:0];
    wdata = value_i;
    if (cmd_i.load) begin
      we = (count_q < CapCount);
    end else if (cmd_i.shift) begin
      we    = 1'b1;
      waddr = hole_q[AW-1:0];
      wdata = rdata;
    end else if (cmd_i.place) begin
      we    = 1'b1;
      waddr = hole_q[AW-1:0];
      wdata = held_q;
    end

    re    = 1'b0;
    raddr = pos_q[AW-1:0];
    if (cmd_i.pos_rd) begin
      re = 1'b1;
    end else if (cmd_i.pos_latch) begin
      re    = 1'b1;
      raddr = pos_dn[AW-1:0];
    end else if (cmd_i.shift) begin
      re    = status_o.hole_more;
      raddr = hole_dn[AW-1:0] - gap_q[AW-1:0];
    end else if (cmd_i.out_rd) begin
      re    = 1'b1;
      raddr = idx_q[AW-1:0];
    end
  end

  ssu_ram #(
    .WIDTH(DataWidth),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Element count and overflow flag for the current set.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.load) begin
      if (count_q < CapCount) begin
        count_q <= count_q + CW'(1);
      end else begin
        ovf_q <= 1'b1;
      end
    end else if (cmd_i.out_ld && status_o.out_last) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end
  end

  // Sort indexes and the held element.
  always_ff @(posedge clk_i) begin
    if (cmd_i.gap_init) begin
      gap_q <= half_count;
      pos_q <= half_count;
      idx_q <= '0;
    end
    if (cmd_i.gap_next) begin
      gap_q <= half_gap;
      pos_q <= half_gap;
    end
    if (cmd_i.place && !status_o.pos_end) begin
      pos_q <= pos_inc;
    end
    if (cmd_i.pos_latch) begin
      held_q <= $signed(rdata);
      hole_q <= pos_q;
    end
    if (cmd_i.shift) begin
      hole_q <= hole_dn;
    end
    if (cmd_i.out_ld) begin
      idx_q <= idx_inc;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_value_q <= $signed(rdata);
      out_last_q  <= status_o.out_last;
      out_trunc_q <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_res_o     = out_last_q;
  assign truncated_o    = out_trunc_q;

endmodule

@@ sv/shell_sorter_unit.sv @@
// Shell sorter: elements load one per cycle into a single simple dual-port
// store of MAX_ITEMS entries until a request marked last arrives; elements
// past capacity are dropped and every result of that set is flagged as
// truncated. The sort then runs gapped insertion passes with gaps halving
// from count/2 down to 1: each position is read, latched while the element
// one gap below is read, compared, and placed, with every larger element
// shifted up one gap on the way down; the compare after the last shift is
// skipped when the shifts run down to the bottom of the set. Setting the
// first gap and each later gap update take a step of their own.
// Each result is then read from the store and loaded into the output
// register once that register is free.
// The input side stalls from the last request until the final result has
// been loaded into the output register.
module shell_sorter_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ssu_pkg::DataWidth-1:0] value_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [ssu_pkg::DataWidth-1:0] sorted_value_o,
  output logic                                 last_res_o,
  output logic                                 truncated_o
);

  import ssu_pkg::*;

  ssu_cmd_t    cmd;
  ssu_status_t status;

  // Sequencer.
  ssu_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .last_i    (last_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Store, indexes, comparator and output register.
  ssu_dpath #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .value_i       (value_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .truncated_o   (truncated_o)
  );

endmodule

@@ tb/sort_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the shell sorter, predicts the sorted stream of
// every completed set and compares each accepted result against it.
module sort_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [ssu_pkg::DataWidth-1:0] value_i,
  input  logic                                 last_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [ssu_pkg::DataWidth-1:0] sorted_value_i,
  input  logic                                 last_res_i,
  input  logic                                 truncated_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);

  typedef logic signed [ssu_pkg::DataWidth-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  truncated;
  } sorted_result_t;

  // Elements kept for the set in progress and whether any were dropped.
  elem_t          kept_q[$];
  logic           dropped = 1'b0;
  sorted_result_t sorted_q[$];
  int unsigned    mismatches = 0;

  // Gapped insertion passes with gaps of half the count down to one.
  function automatic void shell_sort_kept();
    int unsigned gap;
    int unsigned pos;
    int unsigned hole;
    elem_t       held;
    gap = kept_q.size() / 2;
    while (gap > 0) begin
      for (pos = gap; pos < kept_q.size(); pos++) begin
        held = kept_q[pos];
        hole = pos;
        while (hole >= gap && kept_q[hole - gap] > held) begin
          kept_q[hole] = kept_q[hole - gap];
          hole -= gap;
        end
        kept_q[hole] = held;
      end
      gap /= 2;
    end
  endfunction

  // Sorts the finished set, queues its results and starts a fresh set.
  function automatic void close_set();
    sorted_result_t res;
    shell_sort_kept();
    for (int unsigned k = 0; k < kept_q.size(); k++) begin
      res.value     = kept_q[k];
      res.last      = (k + 1 == kept_q.size());
      res.truncated = dropped;
      sorted_q.push_back(res);
    end
    kept_q.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sorted_result_t want;
    if (!rst_ni) begin
      kept_q.delete();
      sorted_q.delete();
      dropped = 1'b0;
    end else begin
      // Compare each accepted result with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        if (sorted_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result value %0d last %0b truncated %0b",
                     $realtime, sorted_value_i, last_res_i, truncated_i);
          end
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          if (sorted_value_i !== want.value || last_res_i !== want.last ||
              truncated_i !== want.truncated) begin
            if (mismatches < 10) begin
              $display("%0t: expected value %0d last %0b truncated %0b, got %0d %0b %0b",
                       $realtime, want.value, want.last, want.truncated,
                       sorted_value_i, last_res_i, truncated_i);
            end
            mismatches++;
          end
        end
      end
      // Collect accepted requests; past capacity they are only flagged.
      if (in_valid_i && !in_stall_i) begin
        if (kept_q.size() < MAX_ITEMS) begin
          kept_q.push_back(value_i);
        end else begin
          dropped = 1'b1;
        end
        if (last_i) begin
          close_set();
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= sorted_q.size();
  end

endmodule

@@ tb/tb_shell_sorter_unit.sv @@
`timescale 1ns / 100ps

module tb_shell_sorter_unit;

  typedef logic signed [ssu_pkg::DataWidth-1:0] elem_t;

  localparam int unsigned MaxItems    = 64;
  localparam int unsigned TargetItems = 500;
  localparam int unsigned IdleLimit   = 50000;
  localparam elem_t MinVal = {1'b1, {(ssu_pkg::DataWidth-1){1'b0}}};
  localparam elem_t MaxVal = {1'b0, {(ssu_pkg::DataWidth-1){1'b1}}};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  elem_t       value_i     = '0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  elem_t       sorted_value_o;
  logic        last_res_o;
  logic        truncated_o;

  logic        calm        = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent  = 0;
  int unsigned fail_count;
  int unsigned pending;
  elem_t       set_q[$];

  shell_sorter_unit #(
    .MAX_ITEMS(MaxItems)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_res_o    (last_res_o),
    .truncated_o   (truncated_o)
  );

  sort_checker #(
    .MAX_ITEMS(MaxItems)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_i(sorted_value_o),
    .last_res_i    (last_res_o),
    .truncated_i   (truncated_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #5 clk_i = ~clk_i;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  // Element values: full range, a narrow band that repeats, and the extremes.
  function automatic elem_t rand_value();
    elem_t pick;
    case ($urandom_range(0, 3))
      0:       pick = $urandom_range(0, 16) - 8;
      1:       pick = ($urandom_range(0, 1) == 1) ? MaxVal : MinVal;
      default: pick = $urandom;
    endcase
    return pick;
  endfunction

  // Sends one request, holding valid high across back-to-back requests.
  task automatic send_element(input elem_t v, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Sends the queued set with the last mark on its final element.
  task automatic send_set();
    calm <= ($urandom_range(0, 5) == 0);
    for (int unsigned k = 0; k < set_q.size(); k++) begin
      send_element(set_q[k], k + 1 == set_q.size());
    end
    set_q.delete();
  endtask

  task automatic send_random_set(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      set_q.push_back(rand_value());
    end
    send_set();
  endtask

  // The receiver stalls at random, in bursts of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left  <= pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog on cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-element sets at both extremes.
    set_q = '{MinVal};
    send_set();
    set_q = '{MaxVal};
    send_set();
    // Extremes mixed with duplicates, including equal extremes.
    set_q = '{MaxVal, MinVal, 0, -1, 1, 5, 5, -5, MinVal, MaxVal};
    send_set();
    // Strictly descending input forces shifts in every pass.
    set_q = '{6, 5, 4, 3, 2, 1};
    send_set();
    // Already sorted input needs no shifts.
    set_q = '{-2, 0, 3, 7};
    send_set();

    // A set that exactly fills the store, then one that overflows it.
    send_random_set(MaxItems);
    send_random_set(MaxItems + $urandom_range(1, 6));

    // Random sets, mostly small, with an occasional one near capacity.
    while (items_sent < TargetItems) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random_set($urandom_range(MaxItems - 8, MaxItems + 8));
      end else begin
        send_random_set($urandom_range(1, 16));
      end
    end
    in_valid_i <= 1'b0;

    // Drain all predicted results, then allow for stray late outputs.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ shell_sorter_unit.f @@
sv/ssu_pkg.sv
sv/ssu_ram.sv
sv/ssu_ctrl.sv
sv/ssu_dpath.sv
sv/shell_sorter_unit.sv
tb/sort_checker.sv
tb/tb_shell_sorter_unit.sv
